>>> hdl/rmq_pkg.sv
// Package with shared constants and types for the rotation-matrix-to-quaternion unit.
`timescale 1ns / 1ps
package rmq_pkg;
   localparam int FracBitsDefault = 14;
   localparam int DataWidth = 16;

   typedef enum logic [1:0] {
      SEL_X     = 2'd0,
      SEL_Y     = 2'd1,
      SEL_Z     = 2'd2,
      SEL_TRACE = 2'd3
   } sel_type;
endpackage

>>> hdl/rmq_stream_if.sv
// Valid/ready channel interface carrying a generic payload.
`timescale 1ns / 1ps
interface rmq_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/rmq_sqrt_cell.sv
// One cell of the pipelined square root: retires one result bit per cycle while enabled.
`timescale 1ns / 1ps
module rmq_sqrt_cell #(
   parameter int RadWidth = 36,
   parameter int RootWidth = 18,
   parameter int Step = 0
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [RadWidth-1:0]  rem_in,
   input  logic [RootWidth-1:0] root_in,
   output logic [RadWidth-1:0]  rem_out,
   output logic [RootWidth-1:0] root_out
);
   localparam int Pos = RootWidth - 1 - Step;
   localparam int Shift = 2 * Pos;

   logic [RadWidth+1:0] trial;
   logic [RadWidth-1:0] rem_ff, rem_in_w;
   logic [RootWidth-1:0] root_ff, root_in_w;

   always_comb begin
      trial = ((RadWidth+2)'(root_in) << (Pos + 1)) + ((RadWidth+2)'(1) << Shift);
      if ({2'b0, rem_in} >= trial) begin
         rem_in_w  = rem_in - trial[RadWidth-1:0];
         root_in_w = root_in | (RootWidth'(1) << Pos);
      end else begin
         rem_in_w  = rem_in;
         root_in_w = root_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in_w;
         root_ff <= root_in_w;
      end
   end

   assign rem_out  = rem_ff;
   assign root_out = root_ff;
endmodule

>>> hdl/rmq_div_cell.sv
// One cell of the pipelined divider: retires one quotient bit per cycle for three lanes while enabled.
`timescale 1ns / 1ps
module rmq_div_cell #(
   parameter int NumWidth = 33,
   parameter int DenWidth = 19,
   parameter int Step = 0
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [DenWidth-1:0]        den_in,
   input  logic [2:0][NumWidth-1:0]   num_in,
   input  logic [2:0][DenWidth:0]     rem_in,
   output logic [DenWidth-1:0]        den_out,
   output logic [2:0][NumWidth-1:0]   num_out,
   output logic [2:0][DenWidth:0]     rem_out
);
   logic [2:0][NumWidth-1:0] num_in_w, num_ff;
   logic [2:0][DenWidth:0]   rem_in_w, rem_ff;
   logic [DenWidth-1:0]      den_ff;
   logic [DenWidth+1:0]      shifted;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         shifted = {rem_in[k], num_in[k][NumWidth-1]};
         num_in_w[k] = {num_in[k][NumWidth-2:0], 1'b0};
         if (shifted >= {2'b0, den_in}) begin
            rem_in_w[k] = (DenWidth+1)'(shifted - {2'b0, den_in});
            num_in_w[k][0] = 1'b1;
         end else begin
            rem_in_w[k] = shifted[DenWidth:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff <= den_in;
         num_ff <= num_in_w;
         rem_ff <= rem_in_w;
      end
   end

   assign den_out = den_ff;
   assign num_out = num_ff;
   assign rem_out = rem_ff;
endmodule

>>> hdl/rotation_matrix_to_quaternion_unit.sv
// Top level of the rotation-matrix-to-quaternion unit.
// Converts a row-major 3x3 rotation matrix, nine signed Q(FRAC_BITS) elements, into a
// unit quaternion (x, y, z, w) in the same format using Shepperd's method.
// Channels: req_ is the matrix input, rsp_ the quaternion result, both valid/ready;
// a transfer happens at a rising edge with valid and ready high.
// Pipeline: the input stage, the bit-serial chain of square-root cells, the divider
// cells and the output stage, each registered in turn.
// Throughput: one matrix per cycle while the receiver does not stall; every cell advances together.
// The whole pipeline moves whenever the last stage is empty or being taken, so a
// stalled receiver freezes all stages and deasserts req_ready; nothing is lost.
// Synchronous reset clears all valid flags; payload registers are not reset.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit #(
   parameter int FRAC_BITS = rmq_pkg::FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_r00, input logic [15:0] req_r01, input logic [15:0] req_r02,
   input  logic [15:0] req_r10, input logic [15:0] req_r11, input logic [15:0] req_r12,
   input  logic [15:0] req_r20, input logic [15:0] req_r21, input logic [15:0] req_r22,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_quat_x,
   output logic [15:0] rsp_quat_y,
   output logic [15:0] rsp_quat_z,
   output logic [15:0] rsp_quat_w
);
   localparam int TWidth = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
   localparam int RadWidth = TWidth + FRAC_BITS;
   localparam int RootWidth = (RadWidth + 1) / 2;
   localparam int NWidth = 18;
   localparam int NumWidth = NWidth + FRAC_BITS;
   localparam int DenWidth = RootWidth + 1;
   localparam int Depth = 1 + RootWidth + NumWidth + 1;

   typedef struct packed {
      rmq_pkg::sel_type sel;
      logic [2:0]       neg;
   } ctl_type;

   logic [Depth-1:0] vld_ff;
   logic             adv;
   assign adv = !vld_ff[Depth-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Depth-2:0], req_valid};
      end
   end

   // Stage 0: branch choice, radicand and numerators.
   logic signed [TWidth-1:0] t_w;
   logic signed [NWidth-1:0] n_w [3];
   rmq_pkg::sel_type sel_w;
   logic [RadWidth-1:0] rad_ff;
   logic [2:0][NWidth-2:0] nmag_ff;
   ctl_type ctl_ff;

   always_comb begin
      logic signed [17:0] a, b, c, e0, e1, e2, e3, e4, e5;
      a = 18'(signed'(req_r00)); b = 18'(signed'(req_r11)); c = 18'(signed'(req_r22));
      e0 = 18'(signed'(req_r01)); e1 = 18'(signed'(req_r10)); e2 = 18'(signed'(req_r02));
      e3 = 18'(signed'(req_r20)); e4 = 18'(signed'(req_r12)); e5 = 18'(signed'(req_r21));
      if (a + b + c >= 0) begin
         sel_w = rmq_pkg::SEL_TRACE;
         t_w = TWidth'(a + b + c) + (TWidth'(1) <<< FRAC_BITS);
         n_w[0] = e5 - e4; n_w[1] = e2 - e3; n_w[2] = e1 - e0;
      end else if (a > ((b > c) ? b : c)) begin
         sel_w = rmq_pkg::SEL_X;
         t_w = TWidth'(a - b - c) + (TWidth'(1) <<< FRAC_BITS);
         n_w[0] = e0 + e1; n_w[1] = e2 + e3; n_w[2] = e5 - e4;
      end else if (b >= c) begin
         sel_w = rmq_pkg::SEL_Y;
         t_w = TWidth'(b - c - a) + (TWidth'(1) <<< FRAC_BITS);
         n_w[0] = e0 + e1; n_w[1] = e4 + e5; n_w[2] = e2 - e3;
      end else begin
         sel_w = rmq_pkg::SEL_Z;
         t_w = TWidth'(c - a - b) + (TWidth'(1) <<< FRAC_BITS);
         n_w[0] = e2 + e3; n_w[1] = e4 + e5; n_w[2] = e1 - e0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rad_ff <= RadWidth'(t_w) << FRAC_BITS;
         ctl_ff.sel <= sel_w;
         for (int k = 0; k < 3; k++) begin
            ctl_ff.neg[k] <= n_w[k][NWidth-1];
            nmag_ff[k] <= (NWidth-1)'(n_w[k][NWidth-1] ? -n_w[k] : n_w[k]);
         end
      end
   end

   // Square-root cells; numerators and control ride along.
   logic [RadWidth-1:0]  srem [RootWidth+1];
   logic [RootWidth-1:0] sroot [RootWidth+1];
   logic [2:0][NWidth-2:0] snum [RootWidth+1];
   ctl_type sctl [RootWidth+1];
   assign srem[0] = rad_ff;
   assign sroot[0] = '0;
   assign snum[0] = nmag_ff;
   assign sctl[0] = ctl_ff;

   for (genvar i = 0; i < RootWidth; i++) begin : g_sqrt
      rmq_sqrt_cell #(.RadWidth(RadWidth), .RootWidth(RootWidth), .Step(i)) u_cell (
         .clock(clock), .enable(adv),
         .rem_in(srem[i]), .root_in(sroot[i]),
         .rem_out(srem[i+1]), .root_out(sroot[i+1]));
      always_ff @(posedge clock) begin
         if (adv) begin
            snum[i+1] <= snum[i];
            sctl[i+1] <= sctl[i];
         end
      end
   end

   // Divider cells: quotient of (mag << FRAC_BITS) + root by 2*root.
   logic [DenWidth-1:0] dden [NumWidth+1];
   logic [2:0][NumWidth-1:0] dnum [NumWidth+1];
   logic [2:0][DenWidth:0] drem [NumWidth+1];
   ctl_type dctl [NumWidth+1];
   logic [RootWidth-1:0] dhalf [NumWidth+1];
   logic [RootWidth-1:0] root_fin;
   assign root_fin = sroot[RootWidth];
   assign dden[0] = {root_fin, 1'b0};
   assign dctl[0] = sctl[RootWidth];
   assign dhalf[0] = RootWidth'(({1'b0, root_fin} + 1'b1) >> 1);
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dnum[0][k] = NumWidth'({snum[RootWidth][k], FRAC_BITS'(0)}) + NumWidth'(root_fin);
         drem[0][k] = '0;
      end
   end

   for (genvar i = 0; i < NumWidth; i++) begin : g_div
      rmq_div_cell #(.NumWidth(NumWidth), .DenWidth(DenWidth), .Step(i)) u_cell (
         .clock(clock), .enable(adv),
         .den_in(dden[i]), .num_in(dnum[i]), .rem_in(drem[i]),
         .den_out(dden[i+1]), .num_out(dnum[i+1]), .rem_out(drem[i+1]));
      always_ff @(posedge clock) begin
         if (adv) begin
            dctl[i+1] <= dctl[i];
            dhalf[i+1] <= dhalf[i];
         end
      end
   end

   // Final stage: sign, saturation and placement.
   localparam int One = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
   localparam int Low = (FRAC_BITS >= 15) ? 32768 : (1 << FRAC_BITS);
   logic [15:0] comp_w [3];
   logic [15:0] half_w;
   logic [15:0] q_ff [4];
   ctl_type fctl;
   assign fctl = dctl[NumWidth];

   always_comb begin
      half_w = (dhalf[NumWidth] > RootWidth'(One)) ? 16'(One) : 16'(dhalf[NumWidth]);
      for (int k = 0; k < 3; k++) begin
         if (fctl.neg[k]) begin
            comp_w[k] = (dnum[NumWidth][k] > NumWidth'(Low)) ?
                        16'(-Low) : 16'(-dnum[NumWidth][k]);
         end else begin
            comp_w[k] = (dnum[NumWidth][k] > NumWidth'(One)) ?
                        16'(One) : 16'(dnum[NumWidth][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         unique case (fctl.sel)
            rmq_pkg::SEL_TRACE: begin
               q_ff[0] <= comp_w[0]; q_ff[1] <= comp_w[1];
               q_ff[2] <= comp_w[2]; q_ff[3] <= half_w;
            end
            rmq_pkg::SEL_X: begin
               q_ff[0] <= half_w; q_ff[1] <= comp_w[0];
               q_ff[2] <= comp_w[1]; q_ff[3] <= comp_w[2];
            end
            rmq_pkg::SEL_Y: begin
               q_ff[0] <= comp_w[0]; q_ff[1] <= half_w;
               q_ff[2] <= comp_w[1]; q_ff[3] <= comp_w[2];
            end
            default: begin
               q_ff[0] <= comp_w[0]; q_ff[1] <= comp_w[1];
               q_ff[2] <= half_w; q_ff[3] <= comp_w[2];
            end
         endcase
      end
   end

   assign rsp_valid = vld_ff[Depth-1];
   assign rsp_quat_x = q_ff[0];
   assign rsp_quat_y = q_ff[1];
   assign rsp_quat_z = q_ff[2];
   assign rsp_quat_w = q_ff[3];

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while the result is stalled");
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_quat_w)))
      else $error("result changed during a stall");
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
endmodule

>>> sim/rmq_tb_pkg.sv
// Transfer types shared by the quaternion unit testbench and its checker.
`timescale 1ns / 1ps
package rmq_tb_pkg;
   typedef struct packed {
      logic [15:0] r00, r01, r02;
      logic [15:0] r10, r11, r12;
      logic [15:0] r20, r21, r22;
   } matrix_type;

   typedef struct packed {
      logic [15:0] quat_x, quat_y, quat_z, quat_w;
   } quat_type;
endpackage

>>> sim/rmq_checker.sv
// Checker that predicts each quaternion from an accepted matrix and compares the results.
`timescale 1ns / 1ps
module rmq_checker #(
   parameter int FRAC_BITS = rmq_pkg::FracBitsDefault
) (
   input  logic clock,
   input  logic reset,
   rmq_stream_if req_mon,
   rmq_stream_if rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   rmq_tb_pkg::quat_type expected_quats[$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= res + bit_val) begin
            v = v - (res + bit_val);
            res = (res >> 1) + bit_val;
         end else begin
            res = res >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return res;
   endfunction

   function automatic longint scaled_quotient(longint n, longint unsigned root);
      longint unsigned mag;
      longint unsigned q;
      mag = (n < 0) ? longint'(-n) : longint'(n);
      q = ((mag << FRAC_BITS) + root) / (root << 1);
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [15:0] saturate(longint v);
      longint unit;
      longint hi;
      longint lo;
      unit = longint'(1) << FRAC_BITS;
      hi = (unit < 32767) ? unit : 32767;
      lo = (-unit > -32768) ? -unit : -32768;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[15:0];
   endfunction

   function automatic rmq_tb_pkg::quat_type matrix_to_quat(rmq_tb_pkg::matrix_type m);
      longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
      longint unit, t, m_diag, half;
      longint unsigned root;
      longint q[4];
      rmq_pkg::sel_type branch;
      rmq_tb_pkg::quat_type res;
      a00 = longint'(signed'(m.r00)); a01 = longint'(signed'(m.r01));
      a02 = longint'(signed'(m.r02)); a10 = longint'(signed'(m.r10));
      a11 = longint'(signed'(m.r11)); a12 = longint'(signed'(m.r12));
      a20 = longint'(signed'(m.r20)); a21 = longint'(signed'(m.r21));
      a22 = longint'(signed'(m.r22));
      unit = longint'(1) << FRAC_BITS;
      if (a00 + a11 + a22 >= 0) begin
         branch = rmq_pkg::SEL_TRACE;
         t = unit + a00 + a11 + a22;
      end else begin
         m_diag = (a11 > a22) ? a11 : a22;
         if (m_diag < a00) begin
            branch = rmq_pkg::SEL_X;
            t = unit + a00 - a11 - a22;
         end else if (a11 >= a22) begin
            branch = rmq_pkg::SEL_Y;
            t = unit + a11 - a22 - a00;
         end else begin
            branch = rmq_pkg::SEL_Z;
            t = unit + a22 - a00 - a11;
         end
      end
      if (t < 1) t = 1;
      root = int_sqrt(longint'(t) << FRAC_BITS);
      if (root == 0) root = 1;
      half = longint'((root + 1) >> 1);
      case (branch)
         rmq_pkg::SEL_TRACE: begin
            q[0] = scaled_quotient(a21 - a12, root);
            q[1] = scaled_quotient(a02 - a20, root);
            q[2] = scaled_quotient(a10 - a01, root);
            q[3] = half;
         end
         rmq_pkg::SEL_X: begin
            q[0] = half;
            q[1] = scaled_quotient(a01 + a10, root);
            q[2] = scaled_quotient(a02 + a20, root);
            q[3] = scaled_quotient(a21 - a12, root);
         end
         rmq_pkg::SEL_Y: begin
            q[0] = scaled_quotient(a01 + a10, root);
            q[1] = half;
            q[2] = scaled_quotient(a12 + a21, root);
            q[3] = scaled_quotient(a02 - a20, root);
         end
         default: begin
            q[0] = scaled_quotient(a02 + a20, root);
            q[1] = scaled_quotient(a12 + a21, root);
            q[2] = half;
            q[3] = scaled_quotient(a10 - a01, root);
         end
      endcase
      res.quat_x = saturate(q[0]);
      res.quat_y = saturate(q[1]);
      res.quat_z = saturate(q[2]);
      res.quat_w = saturate(q[3]);
      return res;
   endfunction

   initial fail_count = 0;
   assign pending_count = expected_quats.size();

   always @(posedge clock) begin
      rmq_tb_pkg::quat_type want;
      rmq_tb_pkg::quat_type got;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready) expected_quats.push_back(matrix_to_quat(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_quats.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10) $display("Unexpected result transfer: %h", got);
            end else begin
               want = expected_quats.pop_front();
               if (got !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("Mismatch: expected x=%h y=%h z=%h w=%h, got x=%h y=%h z=%h w=%h",
                        want.quat_x, want.quat_y, want.quat_z, want.quat_w,
                        got.quat_x, got.quat_y, got.quat_z, got.quat_w);
               end
            end
         end
      end
   end
endmodule

>>> sim/rotation_matrix_to_quaternion_unit_tb.sv
// Testbench top that drives matrices into the quaternion unit and reports the verdict.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_tb;
   localparam int ItemsPerPhase = 425;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   phase = 0;
   int   fail_count;
   int   pending_count;

   rmq_stream_if #(.payload_type(rmq_tb_pkg::matrix_type)) req_if ();
   rmq_stream_if #(.payload_type(rmq_tb_pkg::quat_type)) rsp_if ();

   always #1 clock = ~clock;

   rotation_matrix_to_quaternion_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_ready  (req_if.ready),
      .req_r00    (req_if.payload.r00),
      .req_r01    (req_if.payload.r01),
      .req_r02    (req_if.payload.r02),
      .req_r10    (req_if.payload.r10),
      .req_r11    (req_if.payload.r11),
      .req_r12    (req_if.payload.r12),
      .req_r20    (req_if.payload.r20),
      .req_r21    (req_if.payload.r21),
      .req_r22    (req_if.payload.r22),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .rsp_quat_x (rsp_if.payload.quat_x),
      .rsp_quat_y (rsp_if.payload.quat_y),
      .rsp_quat_z (rsp_if.payload.quat_z),
      .rsp_quat_w (rsp_if.payload.quat_w)
   );

   rmq_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (phase == 2) rsp_if.ready <= ($urandom_range(0, 99) >= 49);
      else if (phase == 3) rsp_if.ready <= ($urandom_range(0, 99) >= 6);
      else rsp_if.ready <= 1'b1;
   end

   function automatic logic [15:0] to_fixed(real v);
      return 16'(int'(v * 16384.0));
   endfunction

   function automatic rmq_tb_pkg::matrix_type random_rotation();
      real x, y, z, w, n;
      rmq_tb_pkg::matrix_type m;
      x = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      y = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      z = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      w = (real'($urandom_range(0, 20000)) - 10000.0) / 10000.0;
      n = $sqrt(x * x + y * y + z * z + w * w);
      if (n < 0.01) begin
         x = 0.0; y = 0.0; z = 0.0; w = 1.0; n = 1.0;
      end
      x = x / n; y = y / n; z = z / n; w = w / n;
      m.r00 = to_fixed(1.0 - 2.0 * (y * y + z * z));
      m.r01 = to_fixed(2.0 * (x * y - z * w));
      m.r02 = to_fixed(2.0 * (x * z + y * w));
      m.r10 = to_fixed(2.0 * (x * y + z * w));
      m.r11 = to_fixed(1.0 - 2.0 * (x * x + z * z));
      m.r12 = to_fixed(2.0 * (y * z - x * w));
      m.r20 = to_fixed(2.0 * (x * z - y * w));
      m.r21 = to_fixed(2.0 * (y * z + x * w));
      m.r22 = to_fixed(1.0 - 2.0 * (x * x + y * y));
      return m;
   endfunction

   function automatic rmq_tb_pkg::matrix_type random_matrix();
      rmq_tb_pkg::matrix_type m;
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
         m = random_rotation();
      end else if (kind < 90) begin
         m.r00 = 16'($urandom_range(0, 32768) - 16384);
         m.r01 = 16'($urandom_range(0, 32768) - 16384);
         m.r02 = 16'($urandom_range(0, 32768) - 16384);
         m.r10 = 16'($urandom_range(0, 32768) - 16384);
         m.r11 = 16'($urandom_range(0, 32768) - 16384);
         m.r12 = 16'($urandom_range(0, 32768) - 16384);
         m.r20 = 16'($urandom_range(0, 32768) - 16384);
         m.r21 = 16'($urandom_range(0, 32768) - 16384);
         m.r22 = 16'($urandom_range(0, 32768) - 16384);
      end else begin
         m = rmq_tb_pkg::matrix_type'({$urandom(), $urandom(), $urandom(), $urandom(),
                                       16'($urandom())});
      end
      return m;
   endfunction

   function automatic rmq_tb_pkg::matrix_type diag_matrix(logic [15:0] d0, logic [15:0] d1,
                                                          logic [15:0] d2, logic [15:0] off);
      rmq_tb_pkg::matrix_type m;
      m.r00 = d0;  m.r01 = off; m.r02 = off;
      m.r10 = off; m.r11 = d1;  m.r12 = off;
      m.r20 = off; m.r21 = off; m.r22 = d2;
      return m;
   endfunction

   task automatic send_matrix(rmq_tb_pkg::matrix_type m);
      int gap;
      gap = 0;
      if (phase == 1) begin
         while ($urandom_range(0, 99) < 49) gap++;
      end else if (phase == 3) begin
         while ($urandom_range(0, 99) < 6) gap++;
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= m;
      do @(posedge clock); while (!req_if.ready);
   endtask

   initial begin
      rmq_tb_pkg::matrix_type directed[$];
      rmq_tb_pkg::matrix_type m;
      int cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(diag_matrix(16'd16384, 16'd16384, 16'd16384, 16'd0));
      directed.push_back(diag_matrix(16'd16384, -16'sd16384, -16'sd16384, 16'd0));
      directed.push_back(diag_matrix(-16'sd16384, 16'd16384, -16'sd16384, 16'd0));
      directed.push_back(diag_matrix(-16'sd16384, -16'sd16384, 16'd16384, 16'd0));
      directed.push_back(diag_matrix(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384));
      directed.push_back(diag_matrix(16'd16384, 16'd16384, 16'd16384, 16'd16384));
      directed.push_back(diag_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000));
      directed.push_back(diag_matrix(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
      directed.push_back(diag_matrix(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
      directed.push_back(diag_matrix(-16'sd100, -16'sd100, -16'sd100, 16'd5000));
      directed.push_back(diag_matrix(-16'sd8000, -16'sd5000, -16'sd5000, 16'd3000));
      directed.push_back(diag_matrix(-16'sd5000, -16'sd5000, -16'sd5000, -16'sd3000));
      directed.push_back(diag_matrix(-16'sd9000, -16'sd5000, -16'sd4000, 16'd2000));
      directed.push_back(diag_matrix(16'd100, -16'sd50, -16'sd50, 16'd0));
      directed.push_back(diag_matrix(16'd0, 16'd0, 16'd0, 16'h7FFF));
      m = diag_matrix(16'd0, 16'd0, -16'sd16384, 16'd0);
      m.r01 = -16'sd16384; m.r10 = 16'd16384;
      directed.push_back(m);
      m = diag_matrix(-16'sd16384, -16'sd16384, -16'sd16384, 16'd0);
      m.r01 = 16'h7FFF; m.r10 = 16'h7FFF; m.r12 = 16'h8000; m.r21 = 16'h8000;
      directed.push_back(m);
      foreach (directed[i]) send_matrix(directed[i]);

      for (phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < ItemsPerPhase; i++) send_matrix(random_matrix());
      end
      req_if.valid <= 1'b0;
      phase = 0;

      cycles = 0;
      while (pending_count != 0 && cycles < 100000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
